>>> rtl/core/magnetometer_autocal_heading_top_macros.svh
// Assertion helpers shared by the RTL modules
`ifndef MAGNETOMETER_AUTOCAL_HEADING_TOP_MACROS_SVH
`define MAGNETOMETER_AUTOCAL_HEADING_TOP_MACROS_SVH

// implication checked on every clock, off during reset
`define MAH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define MAH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/mah_pkg.sv
`default_nettype none
package mah_pkg;
    localparam int HistDepth   = 8;
    localparam int CordicSteps = 16;
    localparam int HistAw      = (HistDepth > 1) ? $clog2(HistDepth) : 1;
    localparam int FillW       = $clog2(HistDepth + 1);
    localparam int SumW        = 20 + $clog2(HistDepth) + 1;
    localparam int AtanN       = 24;
    localparam int NSteps      = (CordicSteps < AtanN) ? CordicSteps : AtanN;
    localparam int StepW       = $clog2(AtanN + 1);
    localparam int AngW        = 28;
    localparam int CordW       = 40;
    localparam logic signed [AngW-1:0] FullTurn = 28'sd23592960;
    localparam logic signed [AngW-1:0] HalfTurn = 28'sd11796480;
    localparam logic [14:0] HeadWrap = 15'd23040;

    localparam logic [2:0] RegMinX = 3'd0;
    localparam logic [2:0] RegMaxX = 3'd1;
    localparam logic [2:0] RegMinY = 3'd2;
    localparam logic [2:0] RegMaxY = 3'd3;
    localparam logic [2:0] RegMinZ = 3'd4;
    localparam logic [2:0] RegMaxZ = 3'd5;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_sample;

    typedef struct packed {
        logic signed [19:0] ax;
        logic signed [19:0] ay;
        logic signed [19:0] az;
        logic [14:0]        hd;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE, ST_BOUND, ST_MEAN, ST_MULA, ST_MULB, ST_DIV, ST_DIVEND,
        ST_HIST, ST_AVG, ST_AVGEND, ST_CORD, ST_CEND, ST_OUT
    } t_state;

    function automatic logic signed [AngW-1:0] atan_of(input logic [StepW-1:0] i);
        logic signed [AngW-1:0] v;
        case (i)
            5'd0: v = 28'sd2949120;   5'd1: v = 28'sd1740967;
            5'd2: v = 28'sd919879;    5'd3: v = 28'sd466945;
            5'd4: v = 28'sd234379;    5'd5: v = 28'sd117304;
            5'd6: v = 28'sd58666;     5'd7: v = 28'sd29335;
            5'd8: v = 28'sd14668;     5'd9: v = 28'sd7334;
            5'd10: v = 28'sd3667;     5'd11: v = 28'sd1833;
            5'd12: v = 28'sd917;      5'd13: v = 28'sd458;
            5'd14: v = 28'sd229;      5'd15: v = 28'sd115;
            5'd16: v = 28'sd57;       5'd17: v = 28'sd29;
            5'd18: v = 28'sd14;       5'd19: v = 28'sd7;
            5'd20: v = 28'sd4;        5'd21: v = 28'sd2;
            5'd22: v = 28'sd1;        default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/magnetometer_autocal_heading_top.sv
`default_nettype none
// Magnetometer min/max auto-calibration with moving average and heading.
// Input stream: s_axis_tdata carries one raw x/y/z sample per transaction.
// Output stream: m_axis_tdata carries the three window averages (Q.4) and
// the heading in 1/64 degree.
// APB port: six 16-bit registers, initial min/max per axis at 4*i; a write
// also reloads the matching running bound. Write only while idle.
// Each result passes the bit-serial calibration divide per axis (skipped for
// an axis whose half-span is zero), the averaging divide per axis and 16
// CORDIC iterations. The back end takes one sample at a time.
// A two-entry input queue takes samples while the back end computes, and
// the output register holds a finished result while the next item starts.
// Reset: bounds return to register reset values, the window empties.
// When the receiver stalls, the result holds and the back end waits.
module magnetometer_autocal_heading_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // raw_x, raw_y, raw_z
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,   // avg_x, avg_y, avg_z, heading_deg, pad
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    mah_pkg::t_sample w_in, w_q;
    mah_pkg::t_result w_res;
    logic w_qv, w_qr, w_we;
    logic signed [15:0] r_reg [6];

    assign w_in.x = s_axis_tdata[15:0];
    assign w_in.y = s_axis_tdata[31:16];
    assign w_in.z = s_axis_tdata[47:32];
    assign pready = 1'b1;
    assign w_we   = psel && penable && pwrite;

    // register file for readback
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg[0] <= -16'sd1227; r_reg[1] <= 16'sd935;
            r_reg[2] <= -16'sd1543; r_reg[3] <= 16'sd711;
            r_reg[4] <= -16'sd760;  r_reg[5] <= 16'sd922;
        end else if (w_we && paddr[1:0] == 2'b00 && paddr[4:2] < 3'd6) begin
            r_reg[paddr[4:2]] <= pwdata[15:0];
        end
    end
    always_comb begin
        prdata = '0;
        if (paddr[4:2] < 3'd6) prdata = 32'(r_reg[paddr[4:2]]);
    end

    mah_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_data(w_q)
    );

    mah_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_data(w_q),
        .i_cfg_we(w_we && paddr[1:0] == 2'b00), .i_cfg_idx(paddr[4:2]),
        .i_cfg_val(pwdata[15:0]),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(w_res)
    );

    assign m_axis_tdata = {5'd0, w_res.hd, w_res.az, w_res.ay, w_res.ax};
endmodule
`default_nettype wire

>>> rtl/core/mah_front.sv
`default_nettype none
// Front end: takes samples and holds them in a two-entry queue
module mah_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire mah_pkg::t_sample i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output mah_pkg::t_sample     o_data
);
    mah_pkg::t_sample r_q [2];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // queue storage and pointers
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

`include "magnetometer_autocal_heading_top_macros.svh"
    `MAH_ASSERT_IMP(a_cnt_range, 1'b1, r_cnt <= 2'd2)
    `MAH_ASSERT_NEXT(a_push_only, w_push && !w_pop, r_cnt == $past(r_cnt) + 2'd1)
    `MAH_ASSERT_IMP(a_ptr_match, r_cnt == 2'd0 || r_cnt == 2'd2, r_wp == r_rp)
endmodule
`default_nettype wire

>>> rtl/core/mah_back.sv
`default_nettype none
// Back end: calibration, moving average and CORDIC heading, one item at a time
module mah_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire mah_pkg::t_sample i_data,
    input  wire logic             i_cfg_we,
    input  wire logic [2:0]       i_cfg_idx,
    input  wire logic signed [15:0] i_cfg_val,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output mah_pkg::t_result      o_data
);
    localparam int HD = mah_pkg::HistDepth;
    localparam int SW = mah_pkg::SumW;
    localparam int CW = mah_pkg::CordW;
    localparam int AW = mah_pkg::AngW;

    mah_pkg::t_state r_st, n_st;
    logic signed [15:0] r_lo [3];
    logic signed [15:0] r_hi [3];
    logic signed [15:0] r_raw [3];
    logic signed [16:0] r_off [3];
    logic signed [16:0] r_half [3];
    logic signed [16:0] r_mean;
    logic signed [19:0] r_cal [3];
    logic signed [19:0] r_hist [3][HD];
    logic signed [SW-1:0] r_sum [3];
    logic signed [19:0] r_avg [3];
    logic [mah_pkg::HistAw-1:0] r_ptr;
    logic [mah_pkg::FillW-1:0]  r_fill;
    logic [1:0] r_ax;
    // shared restoring divider
    logic [51:0] r_dq;
    logic [35:0] r_rem;
    logic [35:0] r_dv;
    logic        r_neg;
    logic [5:0]  r_dcnt;
    logic signed [50:0] r_prod;
    // cordic
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [AW-1:0] r_cz;
    logic [mah_pkg::StepW-1:0] r_ci;
    logic r_zero;
    mah_pkg::t_result r_out;
    logic r_ovalid;

    assign o_valid = r_ovalid;
    assign o_data  = r_out;
    assign o_ready = (r_st == mah_pkg::ST_IDLE);

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            mah_pkg::ST_IDLE:   if (i_valid) n_st = mah_pkg::ST_BOUND;
            mah_pkg::ST_BOUND:  n_st = mah_pkg::ST_MEAN;
            mah_pkg::ST_MEAN:   n_st = mah_pkg::ST_MULA;
            mah_pkg::ST_MULA:   n_st = mah_pkg::ST_MULB;
            mah_pkg::ST_MULB:   n_st = mah_pkg::ST_DIV;
            mah_pkg::ST_DIV:    if (r_dcnt == 6'd0) n_st = mah_pkg::ST_DIVEND;
            mah_pkg::ST_DIVEND: n_st = (r_ax == 2'd2) ? mah_pkg::ST_HIST : mah_pkg::ST_MULA;
            mah_pkg::ST_HIST:   n_st = mah_pkg::ST_AVG;
            mah_pkg::ST_AVG:    if (r_dcnt == 6'd0) n_st = mah_pkg::ST_AVGEND;
            mah_pkg::ST_AVGEND: n_st = (r_ax == 2'd2) ? mah_pkg::ST_CORD : mah_pkg::ST_AVG;
            mah_pkg::ST_CORD:   if (r_ci == mah_pkg::StepW'(mah_pkg::NSteps))
                                    n_st = mah_pkg::ST_CEND;
            mah_pkg::ST_CEND:   n_st = mah_pkg::ST_OUT;
            mah_pkg::ST_OUT:    if (!r_ovalid || i_ready) n_st = mah_pkg::ST_IDLE;
            default:            n_st = mah_pkg::ST_IDLE;
        endcase
    end

    logic signed [16:0] w_lo [3];
    logic signed [16:0] w_hi [3];
    logic signed [17:0] w_s3;
    logic [35:0] w_sub;
    logic signed [CW-1:0] w_shx, w_shy;
    logic signed [AW-1:0] w_ang;
    logic [AW-1:0] w_rnd;
    logic [14:0] w_hd;
    logic signed [38:0] w_mul;
    logic signed [19:0] w_avg;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_lo[a] = 17'(r_lo[a]);
            w_hi[a] = 17'(r_hi[a]);
        end
        w_s3  = 18'(r_half[0]) + 18'(r_half[1]) + 18'(r_half[2]);
        w_sub = {r_rem[34:0], r_dq[51]} - r_dv;
        // 16*(raw-offset) fits 22 bits, the mean 17
        w_mul = $signed(r_prod[21:0]) * r_mean;
        w_avg = r_neg ? -20'(r_dq) : 20'(r_dq);
        w_shx = r_cx >>> r_ci;
        w_shy = r_cy >>> r_ci;
        w_ang = r_cz;
        if (w_ang < 0) w_ang = w_ang + mah_pkg::FullTurn;
        if (w_ang >= mah_pkg::FullTurn) w_ang = w_ang - mah_pkg::FullTurn;
        w_rnd = AW'(w_ang) + AW'(512);
        w_hd  = w_rnd[24:10];
        if (w_hd >= mah_pkg::HeadWrap) w_hd = w_hd - mah_pkg::HeadWrap;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            case (r_st)
                mah_pkg::ST_IDLE: begin
                    r_raw[0] <= i_data.x; r_raw[1] <= i_data.y; r_raw[2] <= i_data.z;
                end
                mah_pkg::ST_MEAN: begin
                    for (int a = 0; a < 3; a++) begin
                        r_off[a]  <= 17'((18'(w_lo[a]) + 18'(w_hi[a])
                                     + ((w_lo[a] + w_hi[a]) < 0 ? 18'sd1 : 18'sd0)) >>> 1);
                        r_half[a] <= 17'((18'(w_hi[a]) - 18'(w_lo[a])
                                     + ((w_hi[a] - w_lo[a]) < 0 ? 18'sd1 : 18'sd0)) >>> 1);
                    end
                end
                mah_pkg::ST_MULA: begin
                    // mean half-span: divide by 3 through the quotient reciprocal
                    if (r_ax == 2'd0) begin
                        r_mean <= 17'(w_s3 < 0 ? -((-36'(w_s3) * 36'sd43691) >>> 17)
                                               : ((36'(w_s3) * 36'sd43691) >>> 17));
                    end
                    r_prod <= 51'(18'(r_raw[r_ax]) - 18'(r_off[r_ax])) * 51'sd16;
                end
                mah_pkg::ST_MULB: begin
                    if (r_half[r_ax] != 0) r_prod <= 51'(w_mul);
                    r_dv   <= 36'(r_half[r_ax] < 0 ? -r_half[r_ax] : r_half[r_ax]);
                    r_rem  <= '0;
                    r_dcnt <= 6'd52;
                end
                mah_pkg::ST_DIV: begin
                    if (r_dcnt == 6'd52 && r_half[r_ax] != 0) begin
                        // dividend sits one bit up so 51 steps cover it
                        r_neg  <= (r_prod < 0) ^ (r_half[r_ax] < 0);
                        r_dq   <= 52'(r_prod < 0 ? -r_prod : r_prod) << 1;
                        r_dcnt <= 6'd51;
                    end else if (r_dcnt != 6'd0) begin
                        if (r_half[r_ax] == 0) begin
                            r_dcnt <= '0;
                        end else begin
                            r_dcnt <= r_dcnt - 6'd1;
                            if (!w_sub[35]) begin
                                r_rem <= w_sub; r_dq <= {r_dq[50:0], 1'b1};
                            end else begin
                                r_rem <= {r_rem[34:0], r_dq[51]}; r_dq <= {r_dq[50:0], 1'b0};
                            end
                        end
                    end
                end
                mah_pkg::ST_DIVEND: begin
                    if (r_half[r_ax] == 0)
                        r_cal[r_ax] <= (r_prod > 51'sd524287) ? 20'sd524287 :
                                       (r_prod < -51'sd524288) ? -20'sd524288 : 20'(r_prod);
                    else if (!r_neg)
                        r_cal[r_ax] <= (r_dq > 52'd524287) ? 20'sd524287 : 20'(r_dq);
                    else
                        r_cal[r_ax] <= (r_dq > 52'd524288) ? -20'sd524288 : 20'(-r_dq);
                    r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                end
                mah_pkg::ST_HIST: begin
                    for (int a = 0; a < 3; a++) begin
                        r_sum[a] <= r_sum[a]
                            - ((r_fill == mah_pkg::FillW'(HD)) ? SW'(r_hist[a][r_ptr]) : '0)
                            + SW'(r_cal[a]);
                        r_hist[a][r_ptr] <= r_cal[a];
                    end
                    r_dcnt <= 6'd52;
                end
                mah_pkg::ST_AVG: begin
                    if (r_dcnt == 6'd52) begin
                        r_neg <= r_sum[r_ax] < 0;
                        r_dq  <= 52'(r_sum[r_ax] < 0 ? -r_sum[r_ax] : r_sum[r_ax]) << (52 - SW);
                        r_dv  <= 36'(r_fill);
                        r_rem <= '0;
                        r_dcnt <= 6'(SW);
                    end else if (r_dcnt != 6'd0) begin
                        r_dcnt <= r_dcnt - 6'd1;
                        if (!w_sub[35]) begin
                            r_rem <= w_sub; r_dq <= {r_dq[50:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[34:0], r_dq[51]}; r_dq <= {r_dq[50:0], 1'b0};
                        end
                    end
                end
                mah_pkg::ST_AVGEND: begin
                    r_avg[r_ax] <= w_avg;
                    r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                    r_dcnt <= 6'd52;
                    if (r_ax == 2'd1) begin
                        // pre-rotate and scale for CORDIC, using x from the first pass
                        r_zero <= (r_avg[0] == 0) && (w_avg == 0);
                        r_cx <= (r_avg[0] < 0) ? -(CW'(r_avg[0]) <<< 16) : (CW'(r_avg[0]) <<< 16);
                        r_cy <= (r_avg[0] < 0) ? -(CW'(w_avg) <<< 16) : (CW'(w_avg) <<< 16);
                        r_cz <= (r_avg[0] < 0) ? mah_pkg::HalfTurn : '0;
                        r_ci <= '0;
                    end
                end
                mah_pkg::ST_CORD: begin
                    if (r_ci != mah_pkg::StepW'(mah_pkg::NSteps)) begin
                        if (r_cy >= 0) begin
                            r_cx <= r_cx + w_shy; r_cy <= r_cy - w_shx;
                            r_cz <= r_cz + mah_pkg::atan_of(r_ci);
                        end else begin
                            r_cx <= r_cx - w_shy; r_cy <= r_cy + w_shx;
                            r_cz <= r_cz - mah_pkg::atan_of(r_ci);
                        end
                        r_ci <= r_ci + 1'b1;
                    end
                end
                mah_pkg::ST_OUT: begin
                    // load the output register only once it is free
                    if (!r_ovalid || i_ready) begin
                        r_out.ax <= r_avg[0]; r_out.ay <= r_avg[1]; r_out.az <= r_avg[2];
                        r_out.hd <= r_zero ? 15'd0 : w_hd;
                    end
                end
                default: ;
            endcase
        end
        // bounds, history control and output flag
        if (!i_rst_n) begin
            r_lo[0] <= -16'sd1227; r_hi[0] <= 16'sd935;
            r_lo[1] <= -16'sd1543; r_hi[1] <= 16'sd711;
            r_lo[2] <= -16'sd760;  r_hi[2] <= 16'sd922;
            for (int a = 0; a < 3; a++) r_sum[a] <= '0;
            r_ptr <= '0; r_fill <= '0; r_ovalid <= 1'b0;
            r_ax <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mah_pkg::RegMinX: r_lo[0] <= i_cfg_val;
                    mah_pkg::RegMaxX: r_hi[0] <= i_cfg_val;
                    mah_pkg::RegMinY: r_lo[1] <= i_cfg_val;
                    mah_pkg::RegMaxY: r_hi[1] <= i_cfg_val;
                    mah_pkg::RegMinZ: r_lo[2] <= i_cfg_val;
                    mah_pkg::RegMaxZ: r_hi[2] <= i_cfg_val;
                    default: ;
                endcase
            end else if (r_st == mah_pkg::ST_BOUND) begin
                // widen the running bounds to the new sample
                for (int a = 0; a < 3; a++) begin
                    if (r_raw[a] < r_lo[a]) r_lo[a] <= r_raw[a];
                    if (r_raw[a] > r_hi[a]) r_hi[a] <= r_raw[a];
                end
            end
            if (r_st == mah_pkg::ST_HIST) begin
                r_ptr <= (r_ptr == mah_pkg::HistAw'(HD - 1)) ? '0 : r_ptr + 1'b1;
                if (r_fill != mah_pkg::FillW'(HD)) r_fill <= r_fill + 1'b1;
            end
            r_ovalid <= (r_st == mah_pkg::ST_OUT && (!r_ovalid || i_ready))
                        || (r_ovalid && !i_ready);
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= mah_pkg::ST_IDLE;
        else          r_st <= n_st;
    end

`include "magnetometer_autocal_heading_top_macros.svh"
    `MAH_ASSERT_IMP(a_fill_max, 1'b1, r_fill <= mah_pkg::FillW'(HD))
    `MAH_ASSERT_NEXT(a_fill_up, r_st == mah_pkg::ST_HIST && r_fill != mah_pkg::FillW'(HD),
        r_fill == $past(r_fill) + 1'b1)
    `MAH_ASSERT_IMP(a_out_hold, r_ovalid && !i_ready && r_st == mah_pkg::ST_OUT,
        n_st == mah_pkg::ST_OUT)
endmodule
`default_nettype wire

>>> test/mah_checker.sv
`timescale 1ns / 100ps
`default_nettype none
// Watches both streams and the register port, computes the expected average
// and heading for every accepted sample, and compares results in order.
module mah_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [79:0] m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               o_fail_cnt,
    output int               o_pending
);
    import mah_pkg::*;

    typedef struct {
        int ax;
        int ay;
        int az;
        int hd;
    } heading_result_t;

    longint bnd_lo[3];
    longint bnd_hi[3];
    longint win_val[3][HistDepth];
    longint win_sum[3];
    int     win_slot;
    int     win_cnt;
    heading_result_t result_q[$];

    function automatic longint fshr(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint clamp_q4(longint v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return v;
    endfunction

    function automatic int heading_of(longint ax, longint ay);
        longint x, y, z, base, nx, ny, ang, r;
        x = ax; y = ay; z = 0; base = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            x = -x; y = -y; base = 180 * 65536;
        end
        x = x * 65536; y = y * 65536;
        for (int i = 0; i < NSteps; i++) begin
            if (y >= 0) begin
                nx = x + fshr(y, i); ny = y - fshr(x, i);
                z += longint'(atan_of(StepW'(i)));
            end else begin
                nx = x - fshr(y, i); ny = y + fshr(x, i);
                z -= longint'(atan_of(StepW'(i)));
            end
            x = nx; y = ny;
        end
        ang = base + z;
        while (ang < 0) ang += 360 * 65536;
        while (ang >= 360 * 65536) ang -= 360 * 65536;
        r = (ang + 512) >>> 10;
        if (r >= 23040) r -= 23040;
        return int'(r);
    endfunction

    // one calibration step on an accepted sample
    task automatic predict_sample(input logic [47:0] d);
        longint raw[3], off[3], half[3], mean, dd, cal, avg[3];
        bit full;
        heading_result_t res;
        full = (win_cnt >= HistDepth);
        for (int a = 0; a < 3; a++) begin
            raw[a] = longint'($signed(d[16*a +: 16]));
            if (raw[a] < bnd_lo[a]) bnd_lo[a] = raw[a];
            if (raw[a] > bnd_hi[a]) bnd_hi[a] = raw[a];
            off[a] = (bnd_lo[a] + bnd_hi[a]) / 2;
            half[a] = (bnd_hi[a] - bnd_lo[a]) / 2;
        end
        mean = (half[0] + half[1] + half[2]) / 3;
        for (int a = 0; a < 3; a++) begin
            dd = raw[a] - off[a];
            cal = (half[a] == 0) ? clamp_q4(dd * 16) : clamp_q4((dd * 16 * mean) / half[a]);
            if (full) win_sum[a] -= win_val[a][win_slot];
            win_val[a][win_slot] = cal;
            win_sum[a] += cal;
        end
        win_slot = (win_slot + 1) % HistDepth;
        if (!full) win_cnt++;
        for (int a = 0; a < 3; a++) avg[a] = win_sum[a] / win_cnt;
        res.ax = int'(avg[0]); res.ay = int'(avg[1]); res.az = int'(avg[2]);
        res.hd = heading_of(avg[0], avg[1]);
        result_q.push_back(res);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            o_fail_cnt++;
        end
    endtask

    assign o_pending = result_q.size();

    always @(posedge i_clk) begin
        heading_result_t e;
        logic [15:0] v;
        if (!i_rst_n) begin
            bnd_lo = '{-1227, -1543, -760};
            bnd_hi = '{935, 711, 922};
            win_sum = '{0, 0, 0};
            win_slot = 0;
            win_cnt = 0;
            result_q.delete();
            o_fail_cnt = 0;
        end else begin
            // register write reloads the matching bound
            if (psel && penable && pwrite && pready) begin
                v = pwdata[15:0];
                case (paddr[4:2])
                    RegMinX: bnd_lo[0] = longint'($signed(v));
                    RegMaxX: bnd_hi[0] = longint'($signed(v));
                    RegMinY: bnd_lo[1] = longint'($signed(v));
                    RegMaxY: bnd_hi[1] = longint'($signed(v));
                    RegMinZ: bnd_lo[2] = longint'($signed(v));
                    RegMaxZ: bnd_hi[2] = longint'($signed(v));
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) predict_sample(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (result_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    o_fail_cnt++;
                end else begin
                    e = result_q.pop_front();
                    check_field("avg_x", e.ax, int'($signed(m_axis_tdata[19:0])));
                    check_field("avg_y", e.ay, int'($signed(m_axis_tdata[39:20])));
                    check_field("avg_z", e.az, int'($signed(m_axis_tdata[59:40])));
                    check_field("heading_deg", e.hd, int'(m_axis_tdata[74:60]));
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> test/tb_magnetometer_autocal_heading_top.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_magnetometer_autocal_heading_top;
    import mah_pkg::*;

    localparam int RandSamples = 730;
    localparam longint CycleLimit = 2_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_cnt;
    int          pending;
    longint      cyc;
    bit          long_hold;

    magnetometer_autocal_heading_top uut (.*);

    mah_checker chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .psel, .penable, .pwrite,
        .paddr, .pwdata, .pready, .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc > CycleLimit) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // receiver stall pattern, with a long hold-off when requested
    initial begin
        int mode;
        m_axis_tready = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                m_axis_tready <= 0;
                repeat (800) @(negedge i_clk);
                long_hold = 0;
            end
            mode = int'((cyc / 3000) % 3);
            m_axis_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0 || mode == 2 &&
                                                   $urandom_range(0, 1) == 1);
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {idx, 2'b00}; pwdata <= {{16{val[15]}}, val};
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z);
        s_axis_tvalid <= 1;
        s_axis_tdata <= {z, y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic pause_sender();
        s_axis_tvalid <= 0;
        repeat ($urandom_range(1, 12)) @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 4000)) - 16'd2000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_bounds(input logic [15:0] v[6]);
        reg_write(RegMinX, v[0]); reg_write(RegMaxX, v[1]);
        reg_write(RegMinY, v[2]); reg_write(RegMaxY, v[3]);
        reg_write(RegMinZ, v[4]); reg_write(RegMaxZ, v[5]);
    endtask

    initial begin
        int burst;
        logic [15:0] b[6];
        long_hold = 0;
        i_rst_n = 0;
        s_axis_tvalid = 0; s_axis_tdata = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: reset bounds, origin, extremes, window wrap
        send_sample(16'd0, 16'd0, 16'd0);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h8000, 16'h7fff, 16'd0);
        send_sample(16'h7fff, 16'h8000, 16'hffff);
        for (int i = 0; i < 6; i++) send_sample(16'(100 * i), 16'(-50 * i), 16'd3);
        drain();

        // zero spans everywhere: scale 1, and zero mean with a nonzero span
        b = '{16'd5, 16'd5, 16'd0, 16'd0, 16'hfff0, 16'hfff0};
        load_bounds(b);
        send_sample(16'd5, 16'd0, 16'hfff0);
        send_sample(16'd6, 16'd0, 16'hfff0);
        send_sample(16'h8000, 16'd0, 16'hfff0);
        drain();
        // inverted bounds and full-range extremes
        b = '{16'h7fff, 16'h8000, 16'd1000, 16'hfc18, 16'd0, 16'd1};
        load_bounds(b);
        send_sample(16'd0, 16'd0, 16'd0);
        send_sample(16'd1, 16'hffff, 16'd0);
        send_sample(16'd0, 16'd20, 16'd0);
        send_sample(16'hffff, 16'd0, 16'd0);
        drain();
        b = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
        load_bounds(b);
        send_sample(16'd1, 16'd1, 16'd1);
        send_sample(16'hffff, 16'd1, 16'd1);
        drain();

        // random phases, every one but the first after a new bound setting
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                for (int k = 0; k < 6; k++)
                    b[k] = (ph == 4) ? 16'($urandom) : 16'($urandom_range(0, 3000)) - 16'd1500;
                load_bounds(b);
            end
            if (ph == 2) long_hold = 1;
            for (int n = 0; n < RandSamples / 5; ) begin
                burst = $urandom_range(1, 20);
                for (int j = 0; j < burst && n < RandSamples / 5; j++, n++)
                    send_sample(rand_axis(), rand_axis(), rand_axis());
                if ($urandom_range(0, 2) != 0) pause_sender();
            end
            drain();
        end

        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+rtl/core
rtl/core/mah_pkg.sv
rtl/core/mah_front.sv
rtl/core/mah_back.sv
rtl/core/magnetometer_autocal_heading_top.sv
test/mah_checker.sv
test/tb_magnetometer_autocal_heading_top.sv
